@@ hdl/ipsm_pkg.sv @@
// Types, constants and address-class helpers for the subnet mask classifier.
package ipsm_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_CLS_A = 32'hFF00_0000;
  localparam logic [31:0] MASK_CLS_B = 32'hFFFF_0000;
  localparam logic [31:0] MASK_CLS_C = 32'hFFFF_FF00;
  localparam logic [31:0] MASK_CLS_D = 32'hFFFF_FFFF;

  localparam logic [7:0] TOP_BIT_A = 8'h80;
  localparam logic [7:0] TOP_BIT_B = 8'h40;
  localparam logic [7:0] TOP_BIT_C = 8'h20;
  localparam logic [7:0] TOP_BIT_D = 8'h10;
  localparam logic [7:0] OCTET_MSK = 8'hFF;

  localparam logic [3:0] NIBBLE_CLS_D = 4'hE;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [31:0] mask_value;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] mask_a;
    logic        is_broadcast;
    logic        is_multicast;
    logic        same_subnet;
    logic        same_net;
  } out_item_t;

  // Lookup and add outcome from the mask table
  typedef struct packed {
    logic        hit_a;
    logic [31:0] mask_a;
    logic        hit_b;
    logic [31:0] mask_b;
    logic        full;
  } cam_rsp_t;

  function automatic logic [31:0] class_mask(input logic [31:0] addr);
    logic [7:0] top;
    top = addr[31:24] & OCTET_MSK;
    if ((top & TOP_BIT_A) == 8'h00)      class_mask = MASK_CLS_A;
    else if ((top & TOP_BIT_B) == 8'h00) class_mask = MASK_CLS_B;
    else if ((top & TOP_BIT_C) == 8'h00) class_mask = MASK_CLS_C;
    else if ((top & TOP_BIT_D) == 8'h00) class_mask = MASK_CLS_D;
    else                                 class_mask = MASK_CLS_A; // class E
  endfunction

  function automatic logic is_class_d(input logic [31:0] addr);
    is_class_d = (addr[31:28] == NIBBLE_CLS_D);
  endfunction

endpackage

@@ hdl/ipsm_cam.sv @@
// Associative subnet mask table: two parallel key lookups and one add per cycle.
module ipsm_cam #(
  parameter int unsigned ENTRIES = ipsm_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              add_en,
  input  logic [31:0]       key_a,
  input  logic [31:0]       key_b,
  input  logic [31:0]       wr_mask,
  output ipsm_pkg::cam_rsp_t rsp
);
  import ipsm_pkg::*;

  logic [ENTRIES-1:0] valid_r;
  logic [31:0]        net_r  [ENTRIES];
  logic [31:0]        mask_r [ENTRIES];

  logic [ENTRIES-1:0] match_a, match_b, sel_a, sel_b, free_sel, wsel;
  logic [31:0]        mux_a, mux_b;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_a[i] = valid_r[i] && (net_r[i] == key_a);
      match_b[i] = valid_r[i] && (net_r[i] == key_b);
    end
    // lowest set bit wins
    sel_a    = match_a & (~match_a + ENTRIES'(1));
    sel_b    = match_b & (~match_b + ENTRIES'(1));
    free_sel = ~valid_r & (valid_r + ENTRIES'(1));
    mux_a = '0;
    mux_b = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      mux_a = mux_a | (sel_a[i] ? mask_r[i] : 32'h0);
      mux_b = mux_b | (sel_b[i] ? mask_r[i] : 32'h0);
    end
    wsel = (|match_a) ? sel_a : free_sel;

    rsp.hit_a  = |match_a;
    rsp.mask_a = mux_a;
    rsp.hit_b  = |match_b;
    rsp.mask_b = mux_b;
    rsp.full   = ~(|match_a) && (&valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (add_en) begin
      valid_r <= valid_r | wsel;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (add_en && wsel[i]) begin
        net_r[i]  <= key_a;
        mask_r[i] <= wr_mask;
      end
    end
  end

endmodule

@@ hdl/ipv4_subnet_mask_classifier_core.sv @@
// Top level of the classful IPv4 subnet mask classifier.
//
// Usage:
//   Input beat: drive in_item and raise start; it is taken at a clock edge
//   where start is high and busy is low. Opcode add stores mask_value for
//   the classful network of addr_a (status reports a full table); opcode
//   query returns the effective mask of addr_a with broadcast, multicast,
//   same-subnet and same-net flags against addr_b.
//   Result beat: out_item is valid for exactly one cycle while out_strobe
//   is high. The receiver cannot stall, so it must take every beat.
//   Path: from the accepting edge the item passes the input register, then
//   lookup logic into the result register.
//   Throughput: 1 item per cycle while busy is low; the table lookup is a
//   parallel compare of all entries, and an add is written at the end of its
//   own compute cycle so the next item already sees it.
//   Reset: synchronous on rst_n; all table entries become invalid, busy is
//   high during reset and drops in the cycle after rst_n is released.
module ipv4_subnet_mask_classifier_core #(
  parameter int unsigned ENTRIES = ipsm_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ipsm_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output ipsm_pkg::out_item_t out_item
);
  import ipsm_pkg::*;

  logic      busy_r;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_strobe_r;
  out_item_t out_item_r, out_item_nxt;

  logic [31:0] addr_a, addr_b, def_a, def_b, key_a, key_b, ma, mb;
  logic        add_en, bc, sub, net;
  cam_rsp_t    rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      in_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      in_vld_r     <= start && !busy_r;
      out_strobe_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign addr_a = in_item_r.addr_a;
  assign addr_b = in_item_r.addr_b;
  assign def_a  = class_mask(addr_a);
  assign def_b  = class_mask(addr_b);
  assign key_a  = addr_a & def_a;
  assign key_b  = addr_b & def_b;
  assign add_en = in_vld_r && (in_item_r.opcode == OP_ADD);

  ipsm_cam #(
    .ENTRIES(ENTRIES)
  ) u_cam (
    .clk     (clk),
    .rst_n   (rst_n),
    .add_en  (add_en),
    .key_a   (key_a),
    .key_b   (key_b),
    .wr_mask (in_item_r.mask_value),
    .rsp     (rsp)
  );

  always_comb begin
    ma  = rsp.hit_a ? rsp.mask_a : def_a;
    mb  = rsp.hit_b ? rsp.mask_b : def_b;
    // host part all zeros or all ones under either mask
    bc  = ((addr_a & ~ma) == 32'h0) || ((addr_a | ma) == ALL_ONES) ||
          ((addr_a & ~def_a) == 32'h0) || ((addr_a | def_a) == ALL_ONES) ||
          (addr_a == ALL_ONES);
    sub = (ma == mb) && ((addr_a & ma) == (addr_b & mb));
    net = ((addr_a & def_a) == (addr_b & def_a));

    out_item_nxt = '0;
    if (in_item_r.opcode == OP_ADD) begin
      out_item_nxt.status = rsp.full ? STATUS_FULL : STATUS_OK;
    end else begin
      out_item_nxt.status       = STATUS_OK;
      out_item_nxt.mask_a       = ma;
      out_item_nxt.is_broadcast = bc;
      out_item_nxt.is_multicast = is_class_d(addr_a);
      out_item_nxt.same_subnet  = sub;
      out_item_nxt.same_net     = net;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // every accepted beat yields a result strobe, through the input and result registers
  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("accepted beat produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_vld_r))
    else $error("result strobe without a pending item");

  a_full_is_add_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == STATUS_FULL) |->
      (out_item.mask_a == 32'h0 && !out_item.same_net && !out_item.is_broadcast))
    else $error("full status carried query fields");

endmodule
